// ----- src/box_smooth_3x3_rgb_defines.svh -----
// Assertion macros for the 3x3 box smoothing block.
// Used by the port checker only; needs a clk and an arst_n in scope.
`ifndef BOX_SMOOTH_3X3_RGB_DEFINES_SVH
`define BOX_SMOOTH_3X3_RGB_DEFINES_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define BSM_ASSERT_CLK(lbl, clock, rstn, prop, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion on the default clk and arst_n.
`define BSM_ASSERT(lbl, prop, msg) \
	`BSM_ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// ----- src/bsm_pkg.sv -----
// Shared types, constants and the divide-by-nine helper for the box smoothing block.
// No dependencies.
package bsm_pkg;

	localparam int CHAN_W      = 8;
	localparam int COORD_W     = 11;
	localparam int CFG_W       = 12;
	localparam int SUM_W       = 12;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 16;
	localparam int MIN_WIDTH   = 3;
	localparam int TAPS        = 9;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 48;

	localparam logic [CFG_W-1:0]   CFG_RESET = 12'd640;
	// floor(2^16 / 9) + 1, exact for every sum below 2^15
	localparam logic [RECIP_W-1:0] RECIP9    = 13'd7282;

	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [SUM_W-1:0]   sum_t;
	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		chan_t blue;
		chan_t green;
		chan_t red;
	} pixel_t;

	typedef struct packed {
		pixel_t two_up;
		pixel_t one_up;
	} line_pair_t;

	typedef struct packed {
		sum_t blue;
		sum_t green;
		sum_t red;
	} sums_t;

	typedef struct packed {
		logic [1:0] pad;
		coord_t     center_col;
		coord_t     center_row;
		pixel_t     mean;
	} out_item_t;

	// Truncating divide by nine through a reciprocal multiply.
	function automatic chan_t div9(input sum_t s);
		logic [SUM_W+RECIP_W-1:0] p;
		p = (SUM_W+RECIP_W)'(s) * (SUM_W+RECIP_W)'(RECIP9);
		return p[RECIP_SHIFT +: CHAN_W];
	endfunction

endpackage

// ----- src/box_smooth_3x3_rgb.sv -----
// 3x3 box smoothing of an RGB raster stream: input, sums and result registers in a row.
// Throughput one pixel per cycle: one line store read and one write per cycle; input stalls only
// while all three stages are full and the result waits.
// Border pixels update the stores but give no result item.
// Reset clears position counters, window and pipeline valids; image_width returns to 640.
module box_smooth_3x3_rgb #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration: image_width
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bsm_pkg::CFG_W-1:0]        cfg_data,
	// input pixels
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [bsm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // in_red, in_green, in_blue
	input  logic [0:0]                       s_axis_tuser,  // frame_start
	// smoothed pixels
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_red, out_green, out_blue, center_row, center_col, 2 bits zero pad
	output logic [bsm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import bsm_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// configuration register: writes must arrive only while idle, which the user ensures; accept always
	logic [CFG_W-1:0] image_width_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= CFG_RESET;
		end else if (cfg_valid) begin
			image_width_q <= cfg_data;
		end
	end

	// Handshake chain: s1 holds the accepted item and its line-store word,
	// s2 the channel sums, s3 the result register on the output.
	logic in_fire;
	logic s1_go;
	logic s2_free;
	logic s3_free;

	logic v_s1;
	logic v_s2;
	logic v_s3;

	assign s3_free       = !v_s3 || m_axis_tready;
	assign s2_free       = !v_s2 || s3_free;
	assign s1_go         = v_s1 && s2_free;
	assign s_axis_tready = !v_s1 || s2_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// position of the pixel being accepted
	logic [CW-1:0] col_in;
	logic [RW-1:0] row_in;
	logic          emit_in;

	bsm_position #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_position (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (in_fire),
		.frame_start(s_axis_tuser[0]),
		.image_width(image_width_q),
		.col        (col_in),
		.row        (row_in),
		.emit       (emit_in)
	);

	// stage 1: input register
	pixel_t        px_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          emit_s1;
	line_pair_t    line_s1;
	line_pair_t    line_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1   <= pixel_t'(s_axis_tdata);
			col_s1  <= col_in;
			row_s1  <= row_in;
			emit_s1 <= emit_in;
		end
	end

	// Read the rows above at acceptance; write back as the item leaves s1.
	// The row above moves down to two-above, the new pixel becomes the row above.
	assign line_wr.two_up = line_s1.one_up;
	assign line_wr.one_up = px_s1;

	bsm_line_store #(
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (s1_go),
		.wr_addr(col_s1),
		.wr_data(line_wr),
		.rd_en  (in_fire),
		.rd_addr(col_in),
		.rd_data(line_s1)
	);

	sums_t sums;

	bsm_window u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (s1_go),
		.top   (line_s1.two_up),
		.mid   (line_s1.one_up),
		.px    (px_s1),
		.sums  (sums)
	);

	// stage 2: sums and centre coordinates; border items drop here
	sums_t  sums_s2;
	coord_t crow_s2;
	coord_t ccol_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			sums_s2 <= sums;
			crow_s2 <= COORD_W'(row_s1 - RW'(1));
			ccol_s2 <= COORD_W'(col_s1 - CW'(1));
		end
	end

	// stage 3: divide by nine into the result register
	out_item_t out_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s3_free) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && v_s2) begin
			out_s3.pad        <= '0;
			out_s3.center_col <= ccol_s2;
			out_s3.center_row <= crow_s2;
			out_s3.mean.red   <= div9(sums_s2.red);
			out_s3.mean.green <= div9(sums_s2.green);
			out_s3.mean.blue  <= div9(sums_s2.blue);
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = out_s3;

endmodule

// ----- src/bsm_line_store.sv -----
// Dual line store: one memory holding the rows one and two above, with read bypass.
// Depends on bsm_pkg.
module bsm_line_store #(
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  bsm_pkg::line_pair_t wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output bsm_pkg::line_pair_t rd_data
);
	import bsm_pkg::*;

	line_pair_t mem [DEPTH];
	line_pair_t rd_q;
	line_pair_t byp_data_q;
	logic       byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// Take the word being written when read and write hit one address together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

// ----- src/bsm_position.sv -----
// Column and row tracking of the incoming pixel, with width clamping and row saturation.
// Depends on bsm_pkg.
module bsm_position #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 2048,
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic                       frame_start,
	input  logic [bsm_pkg::CFG_W-1:0]  image_width,
	output logic [CW-1:0]              col,
	output logic [RW-1:0]              row,
	output logic                       emit
);
	import bsm_pkg::*;

	localparam int LW = ((CW + 1) > CFG_W) ? (CW + 1) : CFG_W;
	localparam logic [LW-1:0] MAXW = LW'(MAX_WIDTH);
	localparam logic [LW-1:0] MINW = LW'(MIN_WIDTH);
	localparam logic [RW-1:0] LAST_ROW = RW'(MAX_HEIGHT - 1);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [LW-1:0] width_ext;
	logic [LW-1:0] eff_width;
	logic [LW-1:0] col_inc;
	logic          row_end;

	assign col = frame_start ? '0 : col_q;
	assign row = frame_start ? '0 : row_q;
	assign emit = (row >= RW'(2)) && (col >= CW'(2));

	always_comb begin
		width_ext = LW'(image_width);
		priority if (width_ext < MINW) begin
			eff_width = MINW;
		end else if (width_ext > MAXW) begin
			eff_width = MAXW;
		end else begin
			eff_width = width_ext;
		end
		col_inc = LW'(col) + LW'(1);
		row_end = col_inc >= eff_width;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (row_end) begin
				col_q <= '0;
				// hold at the last row once reached
				row_q <= (row == LAST_ROW) ? row : row + RW'(1);
			end else begin
				col_q <= CW'(col_inc);
				row_q <= row;
			end
		end
	end

endmodule

// ----- src/bsm_window.sv -----
// 3x3 window registers and the per-channel sums of the nine taps.
// Depends on bsm_pkg.
module bsm_window (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  bsm_pkg::pixel_t top,
	input  bsm_pkg::pixel_t mid,
	input  bsm_pkg::pixel_t px,
	output bsm_pkg::sums_t  sums
);
	import bsm_pkg::*;

	// prev1_q: previous column (top, middle, bottom); prev2_q: the one before
	pixel_t prev1_q [3];
	pixel_t prev2_q [3];
	pixel_t taps [TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				prev1_q[i] <= '0;
				prev2_q[i] <= '0;
			end
		end else if (shift) begin
			prev2_q    <= prev1_q;
			prev1_q[0] <= top;
			prev1_q[1] <= mid;
			prev1_q[2] <= px;
		end
	end

	always_comb begin
		taps[0] = top;
		taps[1] = mid;
		taps[2] = px;
		for (int i = 0; i < 3; i++) begin
			taps[3 + i] = prev1_q[i];
			taps[6 + i] = prev2_q[i];
		end
		sums = '0;
		for (int i = 0; i < TAPS; i++) begin
			sums.red   = sums.red   + SUM_W'(taps[i].red);
			sums.green = sums.green + SUM_W'(taps[i].green);
			sums.blue  = sums.blue  + SUM_W'(taps[i].blue);
		end
	end

endmodule

// ----- src/bsm_checker.sv -----
// Port checker for the box smoothing block and its bind to the top level.
// Depends on box_smooth_3x3_rgb_defines.svh.
`include "box_smooth_3x3_rgb_defines.svh"

module bsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);

	// a stalled result holds
	`BSM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// the result drops only after it has been taken
	`BSM_ASSERT(a_out_drop, $fell(m_axis_tvalid) |-> $past(m_axis_tready), "result dropped untaken")

	// input back-pressure only when every stage is full and the output stalled
	`BSM_ASSERT(a_ready_full, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled with room in pipeline")

	// centre coordinates never in row or column 0, padding zero
	`BSM_ASSERT(a_centre, m_axis_tvalid |-> (m_axis_tdata[34:24] != 11'd0) && (m_axis_tdata[45:35] != 11'd0) && (m_axis_tdata[47:46] == 2'd0), "bad centre or padding")

endmodule

bind box_smooth_3x3_rgb bsm_checker u_checker (.*);

// ----- dv/box_smooth_3x3_rgb_test.sv -----
// Self-checking bench for box_smooth_3x3_rgb: RGB raster frames against an in-bench 3x3 mean predictor.
// Covers directed frames and random frames with width clamps and mid-frame narrowing under stalls.
// Depends on bsm_pkg and the box_smooth_3x3_rgb RTL only.
module box_smooth_3x3_rgb_test;
	import bsm_pkg::*;

	localparam int MAX_W          = 2048;
	localparam int MAX_H          = 2048;
	localparam int WIDTH_AT_RESET = 640;
	localparam int RANDOM_ITEMS   = 1075;
	localparam int MAX_REPORTS    = 10;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_LIMIT    = 20000;
	localparam int HOLD_CYCLES    = 400;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_BUSY,
		RX_SLOW,
		RX_EVERY_THIRD
	} rx_mode_e;

	// one directed pixel; grey expectation typed in where obvious
	typedef struct packed {
		chan_t  r;
		chan_t  g;
		chan_t  b;
		logic   fs;
		logic   typed;
		chan_t  want;
		coord_t want_row;
		coord_t want_col;
	} dir_row_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data      = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // in_red, in_green, in_blue
	logic [0:0]             s_axis_tuser  = '0;  // frame_start
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// out_red, out_green, out_blue, center_row, center_col, 2 bits zero pad
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	box_smooth_3x3_rgb #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor state: its own copy of the line stores, the window,
	// the raster position and the width register.
	// ---------------------------------------------------------------
	pixel_t           row_above     [MAX_W];
	pixel_t           row_two_above [MAX_W];
	pixel_t           win_cols      [6];
	int unsigned      next_col = 0;
	int unsigned      next_row = 0;
	logic [CFG_W-1:0] width_reg = CFG_W'(WIDTH_AT_RESET);
	out_item_t        expected_means [$];

	int fail_count   = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int cfg_writes   = 0;

	// sender pacing and receiver pattern
	int       burst_left    = 0;
	bit       steady_send   = 1'b0;
	int       rx_hold_left  = 0;
	int       rx_mode_left  = 0;
	int       rx_tick       = 0;
	rx_mode_e rx_mode       = RX_FREE;

	// Flat white frame, then a grey step, then a frame restarted mid row.
	dir_row_t directed_rows [25] = '{
		'{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 8'd255, 11'd1, 11'd1},
		'{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'd170, 11'd2, 11'd1},
		'{8'h10, 8'h20, 8'h30, 1'b1, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'h40, 8'h50, 8'h60, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'h70, 8'h80, 8'h90, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'hA0, 8'hB0, 8'hC0, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'hFF, 8'h00, 8'h80, 1'b1, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'h00, 8'hFF, 8'h80, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'hFF, 8'h00, 8'h7F, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'h00, 8'hFF, 8'h01, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'h80, 8'h80, 8'h80, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'hFF, 8'h00, 8'hFE, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'h01, 8'hFF, 8'h00, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0},
		'{8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 8'd0,   11'd0, 11'd0}
	};

	// Width the block actually uses for a register value.
	function automatic int unsigned clamp_width(input logic [CFG_W-1:0] w);
		if (w < MIN_WIDTH)
			return MIN_WIDTH;
		if (w > MAX_W)
			return MAX_W;
		return w;
	endfunction

	// Advance the predictor by one pixel; return 1 with the window mean when the
	// pixel completes an interior window.
	function automatic bit predict_window_mean(input pixel_t px, input bit frame_start,
			output out_item_t mean_out);
		int unsigned eff_w;
		int unsigned c;
		int unsigned r;
		int unsigned idx;
		pixel_t      top;
		pixel_t      mid;
		int          sum_r;
		int          sum_g;
		int          sum_b;
		int          e;
		bit          hit;
		// clamp the width into the supported range
		if (width_reg < MIN_WIDTH)
			eff_w = MIN_WIDTH;
		else if (width_reg > MAX_W)
			eff_w = MAX_W;
		else
			eff_w = width_reg;
		if (frame_start) begin
			next_col = 0;
			next_row = 0;
		end
		c   = next_col;
		r   = next_row;
		idx = c % MAX_W;
		top = row_two_above[idx];
		mid = row_above[idx];
		hit = (r >= 2) && (c >= 2);
		mean_out = '0;
		if (hit) begin
			sum_r = top.red + mid.red + px.red;
			sum_g = top.green + mid.green + px.green;
			sum_b = top.blue + mid.blue + px.blue;
			for (e = 0; e < 6; e++) begin
				sum_r += win_cols[e].red;
				sum_g += win_cols[e].green;
				sum_b += win_cols[e].blue;
			end
			mean_out.mean.red   = chan_t'(sum_r / TAPS);
			mean_out.mean.green = chan_t'(sum_g / TAPS);
			mean_out.mean.blue  = chan_t'(sum_b / TAPS);
			mean_out.center_row = coord_t'(r - 1);
			mean_out.center_col = coord_t'(c - 1);
		end
		// shift the line stores and the window by one column
		row_two_above[idx] = mid;
		row_above[idx]     = px;
		win_cols[3] = win_cols[0];
		win_cols[4] = win_cols[1];
		win_cols[5] = win_cols[2];
		win_cols[0] = top;
		win_cols[1] = mid;
		win_cols[2] = px;
		// end the row at the width; the row count sticks at the last row
		if (c + 1 >= eff_w) begin
			next_col = 0;
			if (next_row < MAX_H - 1)
				next_row++;
		end else begin
			next_col = c + 1;
		end
		return hit;
	endfunction

	function automatic void log_failure(input string what);
		if (fail_count < MAX_REPORTS)
			$display("%0t: mismatch: %s", $time, what);
		fail_count++;
	endfunction

	// Bias channels towards the rails so the extreme sums turn up.
	function automatic chan_t rand_chan();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return chan_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p.red   = rand_chan();
		p.green = rand_chan();
		p.blue  = rand_chan();
		return p;
	endfunction

	// Mostly narrow images; now and then a wide one or an out-of-range width.
	function automatic logic [CFG_W-1:0] rand_width();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 2) begin
			case ($urandom_range(0, 4))
				0: return CFG_W'(0);
				1: return CFG_W'(1);
				2: return CFG_W'(2);
				3: return CFG_W'(MAX_W);
				default: return {CFG_W{1'b1}};
			endcase
		end else if (pick < 5) begin
			return CFG_W'($urandom_range(25, 300));
		end
		return CFG_W'($urandom_range(MIN_WIDTH, 24));
	endfunction

	// Offer one pixel, hold it until taken, then queue what it should produce.
	// Enter and leave on a rising edge.
	task automatic send_pixel(input pixel_t px, input bit fs, input bit use_typed,
			input out_item_t typed_want);
		out_item_t predicted;
		bit        hit;
		if (!steady_send && burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = $urandom_range(1, 48);
		end
		if (burst_left > 0)
			burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		s_axis_tuser  <= fs;
		// tready is settled by the falling edge; the item goes in at the next rise
		do @(negedge clk); while (s_axis_tready !== 1'b1);
		@(posedge clk);
		hit = predict_window_mean(px, fs, predicted);
		if (use_typed)
			expected_means.push_back(typed_want);
		else if (hit)
			expected_means.push_back(predicted);
		items_sent++;
	endtask

	// Drop valid, wait for every queued result, then let the pipeline settle.
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		while (expected_means.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(negedge clk); while (cfg_ready !== 1'b1);
		@(posedge clk);
		cfg_valid <= 1'b0;
		width_reg = value;
		cfg_writes++;
	endtask

	// ---------------------------------------------------------------
	// Receiver: a pattern of its own, switching to a random mode whenever
	// its mode count runs out; a hold request forces a long stall counted here.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		rx_tick++;
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_e'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(64, 400);
			end
			rx_mode_left--;
			case (rx_mode)
				RX_FREE:  m_axis_tready <= 1'b1;
				RX_BUSY:  m_axis_tready <= ($urandom_range(0, 3) != 0);
				RX_SLOW:  m_axis_tready <= ($urandom_range(0, 9) < 3);
				default:  m_axis_tready <= (rx_tick % 3 == 0);
			endcase
		end
	end

	// Output check: decide on the falling edge, when the handshake for the
	// coming rise is already settled.
	always @(negedge clk) begin
		out_item_t got;
		out_item_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			got = m_axis_tdata;
			results_seen++;
			if (expected_means.size() == 0) begin
				log_failure($sformatf("result with nothing expected: rgb %0d/%0d/%0d at (%0d,%0d)",
					got.mean.red, got.mean.green, got.mean.blue,
					got.center_row, got.center_col));
			end else begin
				want = expected_means.pop_front();
				if (got.mean.red !== want.mean.red || got.mean.green !== want.mean.green ||
						got.mean.blue !== want.mean.blue ||
						got.center_row !== want.center_row ||
						got.center_col !== want.center_col || got.pad !== want.pad)
					log_failure($sformatf(
						"want rgb %0d/%0d/%0d at (%0d,%0d), got %0d/%0d/%0d at (%0d,%0d) pad %b",
						want.mean.red, want.mean.green, want.mean.blue,
						want.center_row, want.center_col,
						got.mean.red, got.mean.green, got.mean.blue,
						got.center_row, got.center_col, got.pad));
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin
		dir_row_t         row;
		pixel_t           px;
		out_item_t        want;
		int               i;
		int               k;
		int               n;
		int               phase;
		int               random_items;
		int               left;
		bit               fresh;
		bit               fs;
		logic [CFG_W-1:0] w_next;

		for (i = 0; i < MAX_W; i++) begin
			row_above[i]     = '0;
			row_two_above[i] = '0;
		end
		for (i = 0; i < 6; i++)
			win_cols[i] = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: narrowest image; flat white, a grey step, then a restart mid row.
		write_width(CFG_W'(MIN_WIDTH));
		for (i = 0; i < $size(directed_rows); i++) begin
			row = directed_rows[i];
			px.red   = row.r;
			px.green = row.g;
			px.blue  = row.b;
			want = '0;
			want.mean.red   = row.want;
			want.mean.green = row.want;
			want.mean.blue  = row.want;
			want.center_row = row.want_row;
			want.center_col = row.want_col;
			send_pixel(px, row.fs, row.typed, want);
		end

		// Random frames. The first phase stalls the receiver for a long stretch
		// while pixels keep coming; another pauses the sender until all is out.
		phase        = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			wait_for_results();
			// a phase that does not start a frame changes the width mid frame
			fresh = (phase == 0) || ($urandom_range(0, 4) != 0);
			if (phase == 0)
				w_next = CFG_W'(5);
			else if (fresh)
				w_next = rand_width();
			else
				// narrow only, so every store entry read from row 2 on was written
				// earlier in the same frame
				w_next = CFG_W'($urandom_range(0, clamp_width(width_reg)));
			write_width(w_next);
			steady_send = (phase == 0) || ($urandom_range(0, 3) == 0);
			n     = (phase == 0) ? 300 : $urandom_range(30, 150);
			if (phase == 0)
				rx_hold_left = HOLD_CYCLES;
			for (k = 0; k < n; k++) begin
				if (phase == 3 && k == n / 2)
					wait_for_results();
				fs = (k == 0 && fresh) || ($urandom_range(0, 49) == 0);
				send_pixel(rand_pixel(), fs, 1'b0, '0);
			end
			random_items += n;
			phase++;
		end

		// Drain with a bound, then let the pipeline settle before the verdict.
		s_axis_tvalid <= 1'b0;
		for (i = 0; i < DRAIN_LIMIT && expected_means.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		left = expected_means.size();
		if (left != 0) begin
			log_failure($sformatf("%0d expected results never arrived", left));
			fail_count += left - 1;
		end

		$display("run: %0d pixels, %0d smoothed results, %0d width writes (%0d random phases)",
			items_sent, results_seen, cfg_writes, phase);
		$display("run: widths 0..4095 incl. clamps, long output hold, mid-frame narrowing");
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Hard limit, far beyond the slowest legal run.
	initial begin
		#40_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
